// ===== rtl/core/nlst_pkg.sv =====
// Shared types and constants for the leader succession table.
`timescale 1ns / 1ps

package nlst_pkg;

  localparam int NODE_SLOTS = 32;
  localparam int ID_W       = 5;
  localparam int SLOT_W     = $clog2(NODE_SLOTS);
  localparam int BATT_W     = 7;

  localparam logic [BATT_W-1:0] BATT_THR_RESET = 7'd20;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_SET     = 2'd2,
    REQ_HANDOFF = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_LEADER = 2'd1,
    ST_NO_CAND    = 2'd2,
    ST_NOT_ELIG   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PICK
  } fsm_t;

  // Broadcast command to every cell; each cell matches ids against its own.
  typedef struct packed {
    logic              wr;
    logic              rm;
    logic              chg;
    logic              mark_ll;
    logic [ID_W-1:0]   id;
    logic [BATT_W-1:0] battery;
    logic              healthy;
    logic              link_lost;
    logic              retiring;
    logic [ID_W-1:0]   old_id;
    logic [ID_W-1:0]   new_id;
  } cell_cmd_t;

  // Successor search token, moves one cell per cycle.
  typedef struct packed {
    logic            active;
    logic [ID_W-1:0] first;
    logic [ID_W-1:0] found;
  } scan_t;

  function automatic logic is_slot(input logic [ID_W-1:0] id);
    return int'(id) < NODE_SLOTS;
  endfunction

endpackage

// ===== rtl/core/nlst_cell.sv =====
// One node record with its eligibility check and one stage of the successor search.
`timescale 1ns / 1ps

module nlst_cell
  import nlst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [ID_W-1:0]   my_id,
  input  cell_cmd_t         cmd,
  input  logic [BATT_W-1:0] thr,
  input  logic [ID_W-1:0]   skip_id,
  input  scan_t             scan_in,
  output scan_t             scan_out,
  output logic              elig
);

  logic              present;
  logic              healthy;
  logic [BATT_W-1:0] battery;
  logic              link_lost;
  logic              retiring;
  scan_t             scan_q;
  scan_t             scan_next;
  logic              hit;

  assign hit = cmd.id == my_id;

  // id 0 never qualifies
  assign elig = (my_id != '0) && present && healthy && !link_lost && !retiring &&
                (battery >= thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= 1'b0;
      healthy   <= 1'b0;
      link_lost <= 1'b0;
      retiring  <= 1'b0;
    end else if (cmd.wr && hit) begin
      present   <= 1'b1;
      healthy   <= cmd.healthy;
      link_lost <= cmd.link_lost;
      retiring  <= cmd.retiring;
    end else if (cmd.rm && hit) begin
      present   <= 1'b0;
      healthy   <= 1'b0;
      link_lost <= 1'b0;
      retiring  <= 1'b0;
    end else if (cmd.chg && present) begin
      if (my_id == cmd.old_id || my_id == cmd.new_id) begin
        retiring <= 1'b0;
      end
      if (cmd.mark_ll && my_id == cmd.old_id) begin
        link_lost <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && hit) begin
      battery <= cmd.battery;
    end
  end

  // first: lowest eligible id other than skip_id; found: lowest eligible id above skip_id
  always_comb begin
    scan_next = scan_in;
    if (scan_in.active && elig && my_id != skip_id) begin
      if (my_id > skip_id && scan_in.found == '0) begin
        scan_next.found = my_id;
      end
      if (scan_in.first == '0) begin
        scan_next.first = my_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_q.active <= 1'b0;
    end else begin
      scan_q.active <= scan_next.active;
    end
  end

  always_ff @(posedge clk) begin
    scan_q.first <= scan_next.first;
    scan_q.found <= scan_next.found;
  end

  assign scan_out = scan_q;

endmodule

// ===== rtl/core/next_id_leader_succession_table.sv =====
// Top level: request control, leader register and the row of node cells.
`timescale 1ns / 1ps

// Node table with leader set and ring-successor hand-off. Each request gives
// one result. Writes, removes, set-leader requests, rejected hand-offs and
// hand-offs to an eligible manual choice go through accept and execute; one
// that needs the successor search adds scan and pick, as the search token
// walks the cell row one cell per cycle and the row holds NODE_SLOTS cells.
// A new request is taken while the previous result still waits in the output
// register; it finishes once that register frees up. The battery threshold is
// written through cfg; the user must write it only while idle; no check in the block.
module next_id_leader_succession_table
  import nlst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,   // battery_threshold
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // node_id[4:0], battery_pct[11:5], healthy_flag[12],
                                  // link_lost_flag[13], retiring_flag[14],
                                  // manual_next_id[19:15], zero [23:20]
  input  logic [1:0]  s_tuser,    // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata     // status[1:0], leader_id[6:2], zero [7]
);

  fsm_t              state;
  fsm_t              state_next;
  logic [BATT_W-1:0] thr;
  logic [ID_W-1:0]   leader;
  logic [ID_W-1:0]   leader_next;
  req_t              req;
  logic [ID_W-1:0]   r_id;
  logic [BATT_W-1:0] r_batt;
  logic              r_healthy;
  logic              r_ll;
  logic              r_ret;
  logic [ID_W-1:0]   r_manual;
  logic              o_valid;
  status_t           o_status;
  logic [ID_W-1:0]   o_leader;
  status_t           st;
  logic              load;
  logic              can_load;
  logic              need_scan;
  logic              id_elig;
  logic              manual_elig;
  logic [ID_W-1:0]   cand;
  scan_t             tail_q;
  scan_t             scan_head;
  cell_cmd_t         cmd;
  logic [NODE_SLOTS-1:0] elig;
  scan_t             chain [NODE_SLOTS+1];

  assign cfg_ready = 1'b1;
  assign s_tready  = state == S_IDLE;
  assign m_tvalid  = o_valid;
  assign m_tdata   = {1'b0, o_leader, o_status};
  assign can_load  = !o_valid || m_tready;
  assign chain[0]  = scan_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= BATT_THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req       <= req_t'(s_tuser);
      r_id      <= s_tdata[4:0];
      r_batt    <= s_tdata[11:5];
      r_healthy <= s_tdata[12];
      r_ll      <= s_tdata[13];
      r_ret     <= s_tdata[14];
      r_manual  <= s_tdata[19:15];
    end
  end

  assign id_elig     = is_slot(r_id) && elig[r_id[SLOT_W-1:0]];
  assign manual_elig = (r_manual != '0) && is_slot(r_manual) &&
                       elig[r_manual[SLOT_W-1:0]];
  assign need_scan   = (req == REQ_HANDOFF) && (leader != '0) && (r_id == leader) &&
                       !manual_elig;
  assign cand        = (tail_q.found != '0) ? tail_q.found : tail_q.first;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_EXEC;
      S_EXEC: begin
        if (need_scan) state_next = S_SCAN;
        else if (can_load) state_next = S_IDLE;
      end
      S_SCAN: if (chain[NODE_SLOTS].active) state_next = S_PICK;
      S_PICK: if (can_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.id       = r_id;
    cmd.battery  = r_batt;
    cmd.healthy  = r_healthy;
    cmd.link_lost = r_ll;
    cmd.retiring = r_ret;
    cmd.old_id   = leader;
    cmd.new_id   = leader;
    leader_next  = leader;
    st           = ST_OK;
    load         = 1'b0;
    scan_head    = '0;
    unique case (state)
      S_EXEC: begin
        unique case (req)
          REQ_WRITE: begin
            load   = can_load;
            cmd.wr = can_load;
          end
          REQ_REMOVE: begin
            load   = can_load;
            cmd.rm = can_load;
          end
          REQ_SET: begin
            load = can_load;
            if (id_elig) begin
              cmd.chg     = can_load;
              cmd.new_id  = r_id;
              leader_next = r_id;
            end else begin
              st = ST_NOT_ELIG;
            end
          end
          REQ_HANDOFF: begin
            if (leader == '0 || r_id != leader) begin
              load = can_load;
              st   = ST_NOT_LEADER;
            end else if (manual_elig) begin
              load        = can_load;
              cmd.chg     = can_load;
              cmd.mark_ll = can_load;
              cmd.new_id  = r_manual;
              leader_next = r_manual;
            end else begin
              scan_head.active = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_PICK: begin
        load = can_load;
        if (cand == '0) begin
          st = ST_NO_CAND;
        end else begin
          cmd.chg     = can_load;
          cmd.mark_ll = can_load;
          cmd.new_id  = cand;
          leader_next = cand;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      leader  <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        leader  <= leader_next;
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_status <= st;
      o_leader <= leader_next;
    end
    if (state == S_SCAN && chain[NODE_SLOTS].active) begin
      tail_q <= chain[NODE_SLOTS];
    end
  end

  for (genvar i = 0; i < NODE_SLOTS; i++) begin : g_cell
    nlst_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .my_id    (ID_W'(i)),
      .cmd      (cmd),
      .thr      (thr),
      .skip_id  (leader),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1]),
      .elig     (elig[i])
    );
  end

endmodule
